// ===== src/affine_point_transform_defines.svh =====
// Assertion macros for the affine point transform.
`ifndef AFFINE_POINT_TRANSFORM_DEFINES_SVH
`define AFFINE_POINT_TRANSFORM_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked on aclk outside reset
`define APT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, checked on aclk outside reset
`define APT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define APT_ASSERT_NOW(label, ante, cons, msg)
`define APT_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// ===== src/apt_pkg.sv =====
// Types and constants shared by the affine point transform modules.
`default_nettype none

package apt_pkg;

    // Register indexes of the configuration port
    localparam logic [2:0] REG_ROW0_COLS01 = 3'd0;
    localparam logic [2:0] REG_ROW0_COLS23 = 3'd1;
    localparam logic [2:0] REG_ROW1_COLS01 = 3'd2;
    localparam logic [2:0] REG_ROW1_COLS23 = 3'd3;
    localparam logic [2:0] REG_ROW2_COLS01 = 3'd4;
    localparam logic [2:0] REG_ROW2_COLS23 = 3'd5;

    // Reset values: identity matrix, zero translation
    localparam logic [63:0] RST_ROW0_COLS01 = 64'h0000_0000_0001_0000;
    localparam logic [63:0] RST_ROW0_COLS23 = 64'h0000_0000_0000_0000;
    localparam logic [63:0] RST_ROW1_COLS01 = 64'h0001_0000_0000_0000;
    localparam logic [63:0] RST_ROW1_COLS23 = 64'h0000_0000_0000_0000;
    localparam logic [63:0] RST_ROW2_COLS01 = 64'h0000_0000_0000_0000;
    localparam logic [63:0] RST_ROW2_COLS23 = 64'h0000_0000_0001_0000;

    // Input word: one point, Q16.16
    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
    } apt_in_t;

    // Result word
    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic               clipped;
    } apt_out_t;

    // One matrix row: three coefficients and the translation
    typedef struct packed {
        logic signed [31:0] c0;
        logic signed [31:0] c1;
        logic signed [31:0] c2;
        logic signed [31:0] t;
    } apt_row_coef_t;

    // Stage load enables from the pipeline control
    typedef struct packed {
        logic en1;
        logic en2;
        logic en3;
    } apt_stage_en_t;

endpackage

`default_nettype wire

// ===== src/apt_cfg.sv =====
// Configuration register file holding the 3x4 matrix.
`default_nettype none

module apt_cfg (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   cfg_wr_en,
    input  wire logic [2:0]             cfg_index,
    input  wire logic [63:0]            cfg_wdata,
    output apt_pkg::apt_row_coef_t      row0,
    output apt_pkg::apt_row_coef_t      row1,
    output apt_pkg::apt_row_coef_t      row2
);

    logic [63:0] r0_01_reg, r0_23_reg, r1_01_reg, r1_23_reg, r2_01_reg, r2_23_reg;

    // Register writes; unknown indexes are ignored
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            r0_01_reg <= apt_pkg::RST_ROW0_COLS01;
            r0_23_reg <= apt_pkg::RST_ROW0_COLS23;
            r1_01_reg <= apt_pkg::RST_ROW1_COLS01;
            r1_23_reg <= apt_pkg::RST_ROW1_COLS23;
            r2_01_reg <= apt_pkg::RST_ROW2_COLS01;
            r2_23_reg <= apt_pkg::RST_ROW2_COLS23;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                apt_pkg::REG_ROW0_COLS01: r0_01_reg <= cfg_wdata;
                apt_pkg::REG_ROW0_COLS23: r0_23_reg <= cfg_wdata;
                apt_pkg::REG_ROW1_COLS01: r1_01_reg <= cfg_wdata;
                apt_pkg::REG_ROW1_COLS23: r1_23_reg <= cfg_wdata;
                apt_pkg::REG_ROW2_COLS01: r2_01_reg <= cfg_wdata;
                apt_pkg::REG_ROW2_COLS23: r2_23_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Unpack halves: low half is the lower column
    assign row0 = '{c0: r0_01_reg[31:0], c1: r0_01_reg[63:32],
                    c2: r0_23_reg[31:0], t: r0_23_reg[63:32]};
    assign row1 = '{c0: r1_01_reg[31:0], c1: r1_01_reg[63:32],
                    c2: r1_23_reg[31:0], t: r1_23_reg[63:32]};
    assign row2 = '{c0: r2_01_reg[31:0], c1: r2_01_reg[63:32],
                    c2: r2_23_reg[31:0], t: r2_23_reg[63:32]};

endmodule

`default_nettype wire

// ===== src/apt_row.sv =====
// Three-stage datapath for one output coordinate: multiply, add, round and saturate.
`default_nettype none

module apt_row (
    input  wire logic                    aclk,
    input  wire apt_pkg::apt_stage_en_t  stage_en,
    input  wire apt_pkg::apt_row_coef_t  coef,
    input  wire apt_pkg::apt_in_t        point,
    output logic signed [31:0]           coord,
    output logic                         clip
);

    logic signed [63:0] prod0_reg, prod1_reg, prod2_reg;
    logic signed [63:0] prod0_next, prod1_next, prod2_next;
    logic signed [31:0] trans_reg;
    logic        [64:0] sum_a_reg, sum_b_reg, sum_a_next, sum_b_next;
    logic        [65:0] total;
    logic signed [31:0] coord_reg, coord_next;
    logic               clip_reg, clip_next;

    // Stage 1: three 32x32 signed products, exact Q32.32
    always_comb begin
        prod0_next = coef.c0 * point.pos_x;
        prod1_next = coef.c1 * point.pos_y;
        prod2_next = coef.c2 * point.pos_z;
    end

    always_ff @(posedge aclk) begin
        if (stage_en.en1) begin
            prod0_reg <= prod0_next;
            prod1_reg <= prod1_next;
            prod2_reg <= prod2_next;
            trans_reg <= coef.t;
        end
    end

    // Stage 2: pairwise sums; translation moved up to Q32.32
    always_comb begin
        sum_a_next = {prod0_reg[63], prod0_reg} + {prod1_reg[63], prod1_reg};
        sum_b_next = {prod2_reg[63], prod2_reg}
                   + {{17{trans_reg[31]}}, trans_reg, 16'h0000};
    end

    always_ff @(posedge aclk) begin
        if (stage_en.en2) begin
            sum_a_reg <= sum_a_next;
            sum_b_reg <= sum_b_next;
        end
    end

    // Stage 3: final add, floor by dropping 16 fraction bits, saturate
    always_comb begin
        total = {sum_a_reg[64], sum_a_reg} + {sum_b_reg[64], sum_b_reg};
        // in range when bits 65..47 are all sign
        if ((&total[65:47]) || !(|total[65:47])) begin
            coord_next = total[47:16];
            clip_next  = 1'b0;
        end else if (total[65]) begin
            coord_next = 32'sh8000_0000;
            clip_next  = 1'b1;
        end else begin
            coord_next = 32'sh7FFF_FFFF;
            clip_next  = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en.en3) begin
            coord_reg <= coord_next;
            clip_reg  <= clip_next;
        end
    end

    assign coord = coord_reg;
    assign clip  = clip_reg;

endmodule

`default_nettype wire

// ===== src/affine_point_transform.sv =====
// Affine point transform: top level with pipeline control and matrix registers.
// An accepted input word moves through three register stages (multiply, add,
// round/saturate) to its result word on m_data. Throughput: one word per cycle
// with m_ready high; each stage holds one word, loading when empty or when it drains.
// Reset (aresetn low, synchronous) empties the pipeline and loads the identity matrix.
`default_nettype none

`include "affine_point_transform_defines.svh"

module affine_point_transform (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_wr_en,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [63:0]        cfg_wdata,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire apt_pkg::apt_in_t   s_data,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output apt_pkg::apt_out_t       m_data
);

    apt_pkg::apt_row_coef_t row0, row1, row2;
    apt_pkg::apt_stage_en_t stage_en;
    logic v1_reg, v2_reg, v3_reg;
    logic clip_x, clip_y, clip_z;
    logic signed [31:0] coord_x, coord_y, coord_z;

    apt_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .row0      (row0),
        .row1      (row1),
        .row2      (row2)
    );

    // A stage loads when empty or when the stage after it moves on
    always_comb begin
        stage_en.en3 = !v3_reg || m_ready;
        stage_en.en2 = !v2_reg || stage_en.en3;
        stage_en.en1 = !v1_reg || stage_en.en2;
    end

    assign s_ready = stage_en.en1;

    // Valid bits travel with the words
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (stage_en.en1) v1_reg <= s_valid;
            if (stage_en.en2) v2_reg <= v1_reg;
            if (stage_en.en3) v3_reg <= v2_reg;
        end
    end

    apt_row u_row_x (
        .aclk     (aclk),
        .stage_en (stage_en),
        .coef     (row0),
        .point    (s_data),
        .coord    (coord_x),
        .clip     (clip_x)
    );

    apt_row u_row_y (
        .aclk     (aclk),
        .stage_en (stage_en),
        .coef     (row1),
        .point    (s_data),
        .coord    (coord_y),
        .clip     (clip_y)
    );

    apt_row u_row_z (
        .aclk     (aclk),
        .stage_en (stage_en),
        .coef     (row2),
        .point    (s_data),
        .coord    (coord_z),
        .clip     (clip_z)
    );

    // Result word
    assign m_data  = '{out_x: coord_x, out_y: coord_y, out_z: coord_z,
                       clipped: clip_x | clip_y | clip_z};
    assign m_valid = v3_reg;

    // Checks on the pipeline control
    `APT_ASSERT_NEXT(a_accept_fills_s1, s_valid && s_ready, v1_reg,
        "accepted word did not reach stage 1")
    `APT_ASSERT_NOW(a_stall_only_when_full, !s_ready, v1_reg && v2_reg && v3_reg,
        "input stalled with a bubble in the pipeline")
    `APT_ASSERT_NEXT(a_stage1_holds, v1_reg && !stage_en.en2, v1_reg,
        "stalled word lost from stage 1")

endmodule

`default_nettype wire
